// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, compiled out under SYNTHESIS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define LMTS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define LMTS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LMTS_ASSERT_ALWAYS(label, prop, msg)
`define LMTS_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

// ----- rtl/core/lmts_pkg.sv -----
// ----------------------------------------------------------------------------
// lmts_pkg
// types and constants for the lcd mode timing and status block
// ----------------------------------------------------------------------------
package lmts_pkg;

    // command codes
    localparam logic [1:0] CMD_ADVANCE   = 2'd0;
    localparam logic [1:0] CMD_WR_STATUS = 2'd1;
    localparam logic [1:0] CMD_WR_LYC    = 2'd2;

    // lcd mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // timing in machine cycles
    localparam int unsigned HBLANK_LEN    = 204;
    localparam int unsigned VBLANK_LEN    = 4560;
    localparam int unsigned OAM_LEN       = 80;
    localparam int unsigned XFER_LEN      = 172;
    localparam int unsigned LINE_LEN      = 456;
    localparam int unsigned VISIBLE_LINES = 144;

    localparam int unsigned MODE_CNT_W = 13;
    localparam int unsigned LINE_CNT_W = 10;

    // status register bit positions
    localparam int unsigned STAT_EN_HBLANK = 3;
    localparam int unsigned STAT_EN_VBLANK = 4;
    localparam int unsigned STAT_EN_OAM    = 5;
    localparam int unsigned STAT_EN_LYC    = 6;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] cycles;
        logic [7:0] data;
    } lmts_item_t;

    typedef struct packed {
        logic [7:0] line_number;
        logic [7:0] status_value;
        logic       vblank_request;
        logic       status_request;
        logic       render_request;
        logic [7:0] render_line;
    } lmts_result_t;

endpackage

// ----- rtl/core/lmts_stream_if.sv -----
// ----------------------------------------------------------------------------
// lmts_stream_if
// valid/ready channel carrying one payload word per transaction
// ----------------------------------------------------------------------------
interface lmts_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- rtl/core/lcd_mode_timing_and_stat.sv -----
// ----------------------------------------------------------------------------
// lcd_mode_timing_and_stat
// lcd line/mode timing, status register and interrupt requests
//
//   channel  dir  payload        one transaction is
//   item     in   lmts_item_t    a command: advance, status write, lyc write
//   result   out  lmts_result_t  ly, status and requests after that command
//
// two register stages: input register, then state update and result register
// one command per cycle sustained while the result is not stalled
// the timing state lives beside the result register and updates as a
// command moves into it, so consecutive commands see the state in order
// rst_n clears all state: mode hblank, counters zero, ly and lyc zero
// a stalled result holds both stages; item.ready drops only when both are full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcd_mode_timing_and_stat
    import lmts_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lmts_stream_if.sink   item,
    lmts_stream_if.source result
);

    // pipeline control
    logic         in_valid_reg;
    lmts_item_t   in_item_reg;
    logic         out_valid_reg;
    lmts_result_t out_reg;
    lmts_result_t out_next;
    logic         advance;

    // timing state
    logic [1:0]            mode_reg,        mode_next;
    logic [MODE_CNT_W-1:0] mode_cycles_reg, mode_cycles_next;
    logic [LINE_CNT_W-1:0] line_cycles_reg, line_cycles_next;
    logic [7:0]            scan_line_reg,   scan_line_next;
    logic [7:0]            compare_reg,     compare_next;
    logic [3:0]            enables_reg,     enables_next;

    // datapath intermediates
    logic [MODE_CNT_W:0]   mc_sum;
    logic [MODE_CNT_W-1:0] mc_sat;
    logic [MODE_CNT_W-1:0] mode_len;
    logic [LINE_CNT_W-1:0] lc_sum;
    logic                  line_done;
    logic [7:0]            line_inc;
    logic                  stat_rq;
    logic                  vb_rq;
    logic                  rend_rq;
    logic [7:0]            rend_line;

    assign advance    = !out_valid_reg || result.ready;
    assign item.ready = !in_valid_reg || advance;

    always_comb
    begin
        mc_sum = {1'b0, mode_cycles_reg} + (MODE_CNT_W + 1)'(in_item_reg.cycles);
        // saturate at the all-ones count
        mc_sat = mc_sum[MODE_CNT_W] ? {MODE_CNT_W{1'b1}} : mc_sum[MODE_CNT_W-1:0];
        lc_sum = line_cycles_reg + LINE_CNT_W'(in_item_reg.cycles);
        line_done = (lc_sum >= LINE_CNT_W'(LINE_LEN));
        line_inc  = scan_line_reg + 8'd1;

        case (mode_reg)
            MODE_HBLANK: mode_len = MODE_CNT_W'(HBLANK_LEN);
            MODE_VBLANK: mode_len = MODE_CNT_W'(VBLANK_LEN);
            MODE_OAM:    mode_len = MODE_CNT_W'(OAM_LEN);
            default:     mode_len = MODE_CNT_W'(XFER_LEN);
        endcase
    end

    always_comb
    begin
        mode_next        = mode_reg;
        mode_cycles_next = mode_cycles_reg;
        line_cycles_next = line_cycles_reg;
        scan_line_next   = scan_line_reg;
        compare_next     = compare_reg;
        enables_next     = enables_reg;
        stat_rq          = 1'b0;
        vb_rq            = 1'b0;
        rend_rq          = 1'b0;
        rend_line        = 8'd0;

        case (in_item_reg.cmd)
            CMD_ADVANCE:
            begin
                mode_cycles_next = mc_sat;
                line_cycles_next = lc_sum;
                if (line_done)
                begin
                    line_cycles_next = lc_sum - LINE_CNT_W'(LINE_LEN);
                    if (scan_line_reg < 8'(VISIBLE_LINES))
                    begin
                        rend_rq   = 1'b1;
                        rend_line = scan_line_reg;
                    end
                    scan_line_next = line_inc;
                    if (enables_reg[STAT_EN_LYC-3] && line_inc == compare_reg)
                    begin
                        stat_rq = 1'b1;
                    end
                end

                // at most one mode change per advance
                if (mc_sat >= mode_len)
                begin
                    mode_cycles_next = mc_sat - mode_len;
                    case (mode_reg)
                        MODE_HBLANK:
                        begin
                            if (scan_line_next == 8'(VISIBLE_LINES))
                            begin
                                mode_next = MODE_VBLANK;
                                vb_rq     = 1'b1;
                                if (enables_reg[STAT_EN_VBLANK-3])
                                begin
                                    stat_rq = 1'b1;
                                end
                            end
                            else
                            begin
                                mode_next = MODE_OAM;
                                if (enables_reg[STAT_EN_OAM-3])
                                begin
                                    stat_rq = 1'b1;
                                end
                            end
                        end
                        MODE_VBLANK:
                        begin
                            scan_line_next = 8'd0;
                            mode_next      = MODE_OAM;
                            if (enables_reg[STAT_EN_OAM-3])
                            begin
                                stat_rq = 1'b1;
                            end
                        end
                        MODE_OAM:
                        begin
                            mode_next = MODE_XFER;
                        end
                        default:
                        begin
                            mode_next = MODE_HBLANK;
                            if (enables_reg[STAT_EN_HBLANK-3])
                            begin
                                stat_rq = 1'b1;
                            end
                        end
                    endcase
                end
            end
            CMD_WR_STATUS:
            begin
                if ((in_item_reg.data[STAT_EN_HBLANK] && mode_reg == MODE_HBLANK) ||
                    (in_item_reg.data[STAT_EN_VBLANK] && mode_reg == MODE_VBLANK) ||
                    (in_item_reg.data[STAT_EN_OAM]    && mode_reg == MODE_OAM)    ||
                    (in_item_reg.data[STAT_EN_LYC]    && scan_line_reg == compare_reg))
                begin
                    stat_rq = 1'b1;
                end
                enables_next = in_item_reg.data[STAT_EN_LYC:STAT_EN_HBLANK];
            end
            CMD_WR_LYC:
            begin
                compare_next = in_item_reg.data;
            end
            default:
            begin
                // unused command: no change
            end
        endcase

        out_next.line_number    = scan_line_next;
        out_next.status_value   = {1'b1, enables_next,
                                   scan_line_next == compare_next, mode_next};
        out_next.vblank_request = vb_rq;
        out_next.status_request = stat_rq;
        out_next.render_request = rend_rq;
        out_next.render_line    = rend_line;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            mode_reg        <= MODE_HBLANK;
            mode_cycles_reg <= '0;
            line_cycles_reg <= '0;
            scan_line_reg   <= 8'd0;
            compare_reg     <= 8'd0;
            enables_reg     <= 4'd0;
        end
        else
        begin
            if (item.ready)
            begin
                in_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance && in_valid_reg)
            begin
                mode_reg        <= mode_next;
                mode_cycles_reg <= mode_cycles_next;
                line_cycles_reg <= line_cycles_next;
                scan_line_reg   <= scan_line_next;
                compare_reg     <= compare_next;
                enables_reg     <= enables_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_item_reg <= item.payload;
        end
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    `LMTS_ASSERT_ALWAYS(a_line_cnt_range, line_cycles_reg < LINE_CNT_W'(LINE_LEN), "line counter out of range")
    `LMTS_ASSERT_IMPLIES(a_render_visible, out_valid_reg && out_reg.render_request, out_reg.render_line < 8'(VISIBLE_LINES), "render line not visible")
    `LMTS_ASSERT_IMPLIES(a_vblank_mode, out_valid_reg && out_reg.vblank_request, out_reg.status_value[1:0] == MODE_VBLANK && out_reg.line_number == 8'(VISIBLE_LINES), "vblank request outside vblank entry")
    `LMTS_ASSERT_IMPLIES(a_stall_holds_state, out_valid_reg && !result.ready, ##1 $stable(scan_line_reg) && $stable(mode_reg), "state moved during result stall")

endmodule
